[rtl/bb3_pkg.sv]
package bb3_pkg;

    localparam int PIX_W      = 8;
    localparam int NCH        = 3;
    localparam int RGB_W      = NCH * PIX_W;
    localparam int TDATA_W    = 24;
    localparam int TUSER_W    = 1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 13;

    localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 13'd480;

    // register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // input item kinds
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    localparam int ROW_SUM_W   = 10;
    localparam int SUM_W       = 12;
    localparam int N_W         = 4;
    localparam int NUM_W       = SUM_W + 1;
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = NUM_W + RECIP_W;

    // one window operation, decided when the item is accepted
    typedef struct packed {
        logic             shift;
        logic             emit;
        logic             frame_end;
        logic [2:0]       rmask;
        logic [2:0]       cmask;
        logic [N_W-1:0]   n;
        logic [RGB_W-1:0] px;
    } op_t;

    typedef struct packed {
        logic [NCH-1:0][SUM_W-1:0] chan;
        logic [N_W-1:0]            n;
        logic                      frame_end;
    } sum_t;

    function automatic logic [N_W-1:0] cell_count(input logic [2:0] rm, input logic [2:0] cm);
        logic [N_W-1:0] nr;
        logic [N_W-1:0] nc;
        nr = N_W'(rm[0]) + N_W'(rm[1]) + N_W'(rm[2]);
        nc = N_W'(cm[0]) + N_W'(cm[1]) + N_W'(cm[2]);
        return nr * nc;
    endfunction

    // channel 0 is red, held in the top byte of a packed pixel
    function automatic logic [PIX_W-1:0] chan_of(input logic [RGB_W-1:0] px, input int ch,
                                                 input logic keep);
        logic [PIX_W-1:0] v;
        v = px[(NCH-1-ch)*PIX_W +: PIX_W];
        return keep ? v : '0;
    endfunction

    // ceil(2^18 / n): (2*sum + n) * recip >> 19 gives the rounded mean exactly
    function automatic logic [RECIP_W-1:0] recip(input logic [N_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            4'd1:    r = 19'd262144;
            4'd2:    r = 19'd131072;
            4'd3:    r = 19'd87382;
            4'd4:    r = 19'd65536;
            4'd5:    r = 19'd52429;
            4'd6:    r = 19'd43691;
            4'd7:    r = 19'd37450;
            4'd8:    r = 19'd32768;
            4'd9:    r = 19'd29128;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[rtl/box_blur_3x3_rgb_core.sv]
// channel   dir  handshake            payload
// s_*       in   s_tvalid / s_tready  tdata: red_in, green_in, blue_in; tuser: action
// m_*       out  m_tvalid / m_tready  tdata: red_out, green_out, blue_out; tlast: frame_end
// cfg_*     in   cfg_we               cfg_index, cfg_data
//
// one transaction per cycle if m_tready is high; line buffers read and write once a cycle
// output for frame pixel k comes with input transaction k + width + 1, ignored drains aside
// reset: stream position cleared, width 640, height 480; line buffers are not cleared
// a stall on m_tready backs up through three stages before s_tready drops
module box_blur_3x3_rgb_core
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // red_in, green_in, blue_in
    input  logic [TUSER_W-1:0]    s_tuser,   // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // red_out, green_out, blue_out
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic             accept;
    logic [RGB_W-1:0] pixel;
    logic             op_valid;
    op_t              op;
    logic [AW-1:0]    op_addr;
    logic             sum_valid;
    logic             sum_ready;
    sum_t             sum;

    assign accept = s_tvalid && s_tready;
    // internal pixel packing is red in the top byte
    assign pixel  = {s_tdata[PIX_W-1:0], s_tdata[2*PIX_W-1:PIX_W], s_tdata[3*PIX_W-1:2*PIX_W]};

    bb3_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .action    (s_tuser[0]),
        .pixel     (pixel),
        .op_valid  (op_valid),
        .op        (op),
        .op_addr   (op_addr)
    );

    bb3_window #(.MAX_WIDTH(MAX_WIDTH)) u_window
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op        (op),
        .op_addr   (op_addr),
        .sum_ready (sum_ready),
        .up_ready  (s_tready),
        .sum_valid (sum_valid),
        .sum       (sum)
    );

    bb3_norm u_norm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_valid (sum_valid),
        .sum       (sum),
        .sum_ready (sum_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[rtl/bb3_ram.sv]
module bb3_ram
#(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bb3_ctrl.sv]
module bb3_ctrl
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         accept,
    input  logic                         action,
    input  logic [RGB_W-1:0]             pixel,
    output logic                         op_valid,
    output op_t                          op,
    output logic [$clog2(MAX_WIDTH)-1:0] op_addr
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW    = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int EH    = $clog2(MAX_HEIGHT + 1);

    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [EW-1:0]      drain_reg;
    logic [EW-1:0]      drain_next;
    logic               draining_reg;
    logic               draining_next;
    logic [EW-1:0]      eff_w;
    logic [EH-1:0]      eff_h;

    // out-of-range sizes clamp to 1 and to the buffer limits
    always_comb
    begin
        if (width_reg == '0)
            eff_w = EW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            eff_w = EW'(MAX_WIDTH);
        else
            eff_w = EW'(width_reg);

        if (height_reg == '0)
            eff_h = EH'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            eff_h = EH'(MAX_HEIGHT);
        else
            eff_h = EH'(height_reg);
    end

    // mask bit 0 is the top row / left column of the neighborhood
    always_comb
    begin
        op            = '0;
        op_addr       = '0;
        col_next      = col_reg;
        row_next      = row_reg;
        drain_next    = drain_reg;
        draining_next = draining_reg;

        if (!draining_reg)
        begin
            if (action == ACT_PIXEL)
            begin
                op.shift = 1'b1;
                op.px    = pixel;
                op_addr  = col_reg;
                if (col_reg == '0)
                begin
                    // first column closes the last pixel of output row row_reg - 2
                    op.emit  = (row_reg >= ROW_W'(2));
                    op.rmask = {1'b1, 1'b1, row_reg >= ROW_W'(3)};
                    op.cmask = {1'b0, 1'b1, eff_w >= EW'(2)};
                end
                else
                begin
                    op.emit  = (row_reg >= ROW_W'(1));
                    op.rmask = {1'b1, 1'b1, row_reg >= ROW_W'(2)};
                    op.cmask = {1'b1, 1'b1, col_reg >= COL_W'(2)};
                end

                if (EW'(col_reg) + EW'(1) >= eff_w)
                begin
                    col_next = '0;
                    if (EH'(row_reg) + EH'(1) >= eff_h)
                    begin
                        row_next      = '0;
                        drain_next    = '0;
                        draining_next = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
        end
        else if (drain_reg >= eff_w)
        begin
            // last pixel of the frame, no shift
            op.emit       = 1'b1;
            op.frame_end  = 1'b1;
            op.rmask      = {1'b0, 1'b1, eff_h >= EH'(2)};
            op.cmask      = {1'b0, 1'b1, eff_w >= EW'(2)};
            col_next      = '0;
            row_next      = '0;
            drain_next    = '0;
            draining_next = 1'b0;
        end
        else if (drain_reg == '0)
        begin
            op.shift   = 1'b1;
            op.emit    = (eff_h >= EH'(2));
            op.rmask   = {1'b1, 1'b1, eff_h >= EH'(3)};
            op.cmask   = {1'b0, 1'b1, eff_w >= EW'(2)};
            drain_next = drain_reg + EW'(1);
        end
        else
        begin
            op.shift   = 1'b1;
            op.emit    = 1'b1;
            op_addr    = drain_reg[COL_W-1:0];
            op.rmask   = {1'b0, 1'b1, eff_h >= EH'(2)};
            op.cmask   = {1'b1, 1'b1, drain_reg >= EW'(2)};
            drain_next = drain_reg + EW'(1);
        end

        op.n = cell_count(op.rmask, op.cmask);
    end

    assign op_valid = accept && (op.shift || op.emit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            drain_reg    <= '0;
            draining_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            // any write restarts the stream
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[IMG_H_W-1:0];
                default:          ;
            endcase
            col_reg      <= '0;
            row_reg      <= '0;
            drain_reg    <= '0;
            draining_reg <= 1'b0;
        end
        else if (accept)
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            drain_reg    <= drain_next;
            draining_reg <= draining_next;
        end
    end

endmodule

[rtl/bb3_window.sv]
module bb3_window
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         op_valid,
    input  op_t                          op,
    input  logic [$clog2(MAX_WIDTH)-1:0] op_addr,
    input  logic                         sum_ready,
    output logic                         up_ready,
    output logic                         sum_valid,
    output sum_t                         sum
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic               b_valid_reg;
    op_t                b_op_reg;
    logic [AW-1:0]      b_addr_reg;
    logic               byp_reg;
    logic [RGB_W-1:0]   byp_prev_reg;
    logic [RGB_W-1:0]   byp_prev2_reg;
    logic [RGB_W-1:0]   win1_reg [3];
    logic [RGB_W-1:0]   win2_reg [3];
    logic               s_valid_reg;
    sum_t               s_reg;

    logic [RGB_W-1:0]     prev_q;
    logic [RGB_W-1:0]     prev2_q;
    logic [RGB_W-1:0]     prev_eff;
    logic [RGB_W-1:0]     prev2_eff;
    logic [RGB_W-1:0]     new_col [3];
    logic                 b_adv;
    logic                 b_write;
    logic                 s_free;
    logic [ROW_SUM_W-1:0] row_sum [3];
    sum_t                 sum_next;

    // line buffers: prev holds the row above, prev2 the one above that
    bb3_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_line_prev
    (
        .clk   (clk),
        .we    (b_write),
        .waddr (b_addr_reg),
        .wdata (b_op_reg.px),
        .re    (op_valid && op.shift),
        .raddr (op_addr),
        .rdata (prev_q)
    );

    bb3_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_line_prev2
    (
        .clk   (clk),
        .we    (b_write),
        .waddr (b_addr_reg),
        .wdata (prev_eff),
        .re    (op_valid && op.shift),
        .raddr (op_addr),
        .rdata (prev2_q)
    );

    assign s_free   = !s_valid_reg || sum_ready;
    assign b_adv    = b_valid_reg && (!b_op_reg.emit || s_free);
    assign b_write  = b_adv && b_op_reg.shift;
    assign up_ready = !b_valid_reg || b_adv;

    // forward the column written in the same cycle the next one is read
    assign prev_eff  = byp_reg ? byp_prev_reg  : prev_q;
    assign prev2_eff = byp_reg ? byp_prev2_reg : prev2_q;

    assign new_col[0] = prev2_eff;
    assign new_col[1] = prev_eff;
    assign new_col[2] = b_op_reg.px;

    // left and center columns are the stored ones, right is the incoming column
    always_comb
    begin
        sum_next.n         = b_op_reg.n;
        sum_next.frame_end = b_op_reg.frame_end;
        sum_next.chan      = '0;
        for (int ch = 0; ch < NCH; ch++)
        begin
            for (int kr = 0; kr < 3; kr++)
            begin
                row_sum[kr] =
                    ROW_SUM_W'(chan_of(win1_reg[kr], ch, b_op_reg.rmask[kr] & b_op_reg.cmask[0]))
                  + ROW_SUM_W'(chan_of(win2_reg[kr], ch, b_op_reg.rmask[kr] & b_op_reg.cmask[1]))
                  + ROW_SUM_W'(chan_of(new_col[kr], ch, b_op_reg.rmask[kr] & b_op_reg.cmask[2]));
            end
            sum_next.chan[ch] = SUM_W'(row_sum[0]) + SUM_W'(row_sum[1]) + SUM_W'(row_sum[2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            byp_reg     <= 1'b0;
            s_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                win1_reg[k] <= '0;
                win2_reg[k] <= '0;
            end
        end
        else
        begin
            if (op_valid)
            begin
                b_valid_reg <= 1'b1;
                byp_reg     <= b_write && op.shift && (b_addr_reg == op_addr);
            end
            else if (b_adv)
            begin
                b_valid_reg <= 1'b0;
            end

            if (b_write)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win1_reg[k] <= win2_reg[k];
                    win2_reg[k] <= new_col[k];
                end
            end

            if (b_adv && b_op_reg.emit)
                s_valid_reg <= 1'b1;
            else if (sum_ready)
                s_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_valid)
        begin
            b_op_reg      <= op;
            b_addr_reg    <= op_addr;
            byp_prev_reg  <= b_op_reg.px;
            byp_prev2_reg <= prev_eff;
        end
        if (b_adv && b_op_reg.emit)
        begin
            s_reg <= sum_next;
        end
    end

    assign sum_valid = s_valid_reg;
    assign sum       = s_reg;

endmodule

[rtl/bb3_norm.sv]
module bb3_norm
    import bb3_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sum_valid,
    input  sum_t               sum,
    output logic               sum_ready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast
);

    logic               valid_reg;
    logic [TDATA_W-1:0] data_reg;
    logic               last_reg;

    logic [RECIP_W-1:0] rc;
    logic [NUM_W-1:0]   num  [NCH];
    logic [PROD_W-1:0]  prod [NCH];
    logic [TDATA_W-1:0] data_next;

    assign sum_ready = !valid_reg || m_tready;
    assign rc        = recip(sum.n);

    // rounded mean (2*sum + n) / (2*n) by reciprocal multiply
    always_comb
    begin
        data_next = '0;
        for (int ch = 0; ch < NCH; ch++)
        begin
            num[ch]  = {sum.chan[ch], 1'b0} + NUM_W'(sum.n);
            prod[ch] = PROD_W'(num[ch]) * PROD_W'(rc);
            data_next[ch*PIX_W +: PIX_W] = prod[ch][RECIP_SHIFT +: PIX_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sum_ready)
        begin
            valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_valid && sum_ready)
        begin
            data_reg <= data_next;
            last_reg <= sum.frame_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

[rtl/bb3_checker.sv]
module bb3_checker
    import bb3_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tready,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [TDATA_W-1:0]    m_tdata,
    input  logic                  m_tlast
);

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output payload changed under stall");

    // reset empties the output register
    assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

    // with the output register empty nothing inside can hold up the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output is empty");

    // an empty output register can only stay empty or fill; it never fills straight out of reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(rst_n))
        else $error("output valid straight out of reset");

endmodule

bind box_blur_3x3_rgb_core bb3_checker u_bb3_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
);

[bench/box_blur_3x3_rgb_checker.sv]
`timescale 1ns / 100ps

module box_blur_3x3_rgb_checker
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // red_in, green_in, blue_in
    input  logic [TUSER_W-1:0]    s_tuser,   // action
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [TDATA_W-1:0]    m_tdata,   // red_out, green_out, blue_out
    input  logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    checked
);

    // red sits in the low byte on both streams
    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } rgb_t;

    typedef struct packed {
        logic frame_end;
        rgb_t px;
    } blurred_t;

    rgb_t               row_above  [MAX_WIDTH];
    rgb_t               row_above2 [MAX_WIDTH];
    rgb_t               win        [3][3];
    int                 col_pos;
    int                 row_pos;
    int                 drained;
    bit                 flushing;
    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    blurred_t           blurred_q [$];
    int                 errors;
    int                 compared;

    function automatic int active_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int active_height();
        if (height_reg == 0)
            return 1;
        if (height_reg > MAX_HEIGHT)
            return MAX_HEIGHT;
        return int'(height_reg);
    endfunction

    task automatic slide_window(input int col, input rgb_t px);
        int c;
        c = col % MAX_WIDTH;
        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2]     = row_above2[c];
        win[1][2]     = row_above[c];
        win[2][2]     = px;
        row_above2[c] = row_above[c];
        row_above[c]  = px;
    endtask

    function automatic logic [PIX_W-1:0] rounded_mean(input int sum, input int n);
        if (n == 0)
            return '0;
        return PIX_W'((2 * sum + n) / (2 * n));
    endfunction

    // window column cc holds the column of output pixel (orow, ocol)
    function automatic blurred_t box_mean(input int cc, input int orow, input int ocol,
                                          input logic last);
        int       w;
        int       h;
        int       n;
        int       sr;
        int       sg;
        int       sb;
        int       r;
        int       c;
        int       wc;
        blurred_t res;
        w  = active_width();
        h  = active_height();
        n  = 0;
        sr = 0;
        sg = 0;
        sb = 0;
        for (int kr = 0; kr < 3; kr++)
        begin
            r = orow - 1 + kr;
            if (r >= 0 && r < h)
            begin
                for (int kc = 0; kc < 3; kc++)
                begin
                    c  = ocol - 1 + kc;
                    wc = cc - 1 + kc;
                    if (c >= 0 && c < w && wc >= 0 && wc <= 2)
                    begin
                        sr += int'(win[kr][wc].red);
                        sg += int'(win[kr][wc].green);
                        sb += int'(win[kr][wc].blue);
                        n++;
                    end
                end
            end
        end
        res.px.red    = rounded_mean(sr, n);
        res.px.green  = rounded_mean(sg, n);
        res.px.blue   = rounded_mean(sb, n);
        res.frame_end = last;
        return res;
    endfunction

    task automatic predict_blur(input logic action, input rgb_t px);
        int w;
        int h;
        w = active_width();
        h = active_height();
        if (!flushing)
        begin
            // drains are ignored while pixels are still due
            if (action == ACT_DRAIN)
                return;
            if (col_pos == 0)
            begin
                if (row_pos >= 2)
                    blurred_q.push_back(box_mean(2, row_pos - 2, w - 1, 1'b0));
                slide_window(0, px);
            end
            else
            begin
                slide_window(col_pos, px);
                if (row_pos >= 1)
                    blurred_q.push_back(box_mean(1, row_pos - 1, col_pos - 1, 1'b0));
            end
            if (col_pos + 1 >= w)
            begin
                col_pos = 0;
                if (row_pos + 1 >= h)
                begin
                    row_pos  = 0;
                    drained  = 0;
                    flushing = 1'b1;
                end
                else
                begin
                    row_pos++;
                end
            end
            else
            begin
                col_pos++;
            end
        end
        else if (drained >= w)
        begin
            blurred_q.push_back(box_mean(2, h - 1, w - 1, 1'b1));
            col_pos  = 0;
            row_pos  = 0;
            drained  = 0;
            flushing = 1'b0;
        end
        else
        begin
            // a pixel while flushing counts as a drain, its value dropped
            if (drained == 0)
            begin
                if (h >= 2)
                    blurred_q.push_back(box_mean(2, h - 2, w - 1, 1'b0));
                slide_window(0, '0);
            end
            else
            begin
                slide_window(drained, '0);
                blurred_q.push_back(box_mean(1, h - 1, drained - 1, 1'b0));
            end
            drained++;
        end
    endtask

    function automatic bit field_differs(input string name, input logic [PIX_W-1:0] want,
                                         input logic [PIX_W-1:0] got);
        if (got === want)
            return 1'b0;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        blurred_t want;
        blurred_t got;
        bit       bad;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                row_above[i]  = '0;
                row_above2[i] = '0;
            end
            for (int k = 0; k < 9; k++)
                win[k / 3][k % 3] = '0;
            col_pos    = 0;
            row_pos    = 0;
            drained    = 0;
            flushing   = 1'b0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            blurred_q.delete();
            errors     = 0;
            compared   = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.px        = rgb_t'(m_tdata);
                got.frame_end = m_tlast;
                if (blurred_q.size() == 0)
                begin
                    $display("%0t: expected no transaction, got tdata %06h tlast %0b",
                             $time, m_tdata, m_tlast);
                    errors++;
                end
                else
                begin
                    want = blurred_q.pop_front();
                    bad  = 1'b0;
                    bad |= field_differs("red_out", want.px.red, got.px.red);
                    bad |= field_differs("green_out", want.px.green, got.px.green);
                    bad |= field_differs("blue_out", want.px.blue, got.px.blue);
                    bad |= field_differs("frame_end", {7'b0, want.frame_end},
                                         {7'b0, got.frame_end});
                    if (bad)
                        errors++;
                    compared++;
                end
            end
            // any write restarts the stream, the line buffers stay
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  = cfg_data[IMG_W_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg = cfg_data[IMG_H_W-1:0];
                    default:          ;
                endcase
                col_pos  = 0;
                row_pos  = 0;
                drained  = 0;
                flushing = 1'b0;
            end
            if (s_tvalid && s_tready)
                predict_blur(s_tuser[0], rgb_t'(s_tdata));
        end
        fail_count <= errors;
        pending    <= blurred_q.size();
        checked    <= compared;
    end

endmodule

[bench/box_blur_3x3_rgb_core_tb.sv]
`timescale 1ns / 100ps

module box_blur_3x3_rgb_core_tb;
    import bb3_pkg::*;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int RANDOM_ITEMS  = 640;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata   = '0;   // red_in, green_in, blue_in
    logic [TUSER_W-1:0]    s_tuser   = '0;   // action
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;          // red_out, green_out, blue_out
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int checked;
    bit tx_fast      = 1'b0;
    bit rx_fast      = 1'b0;
    bit rx_hold      = 1'b0;
    int cycles       = 0;
    int accepted     = 0;
    int random_items = 0;
    int frames       = 0;
    int restarts     = 0;
    int cur_w        = 640;
    int cur_h        = 480;

    box_blur_3x3_rgb_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    box_blur_3x3_rgb_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_blur_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** box_blur_3x3_rgb_core: FAILED **");
        $finish;
    end

    // output side: random stalls, plus one long hold on request
    initial
    begin : sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            stall = rx_fast ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid || rx_hold));
        end
    end

    function automatic int clamp_size(input int v, input int limit);
        if (v == 0)
            return 1;
        return (v > limit) ? limit : v;
    endfunction

    task automatic send_item(input logic action, input logic [TDATA_W-1:0] data);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= data;
        do @(posedge clk); while (!s_tready);
        accepted++;
    endtask

    // stop sending until every expected transaction is in, then let the pipe empty
    task automatic wait_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0 && !rx_hold);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [CFG_DATA_W-1:0] wdata,
                              input logic [CFG_DATA_W-1:0] hdata);
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= wdata;
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= hdata;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_w = clamp_size(int'(wdata[IMG_W_W-1:0]), MAX_WIDTH);
        cur_h = clamp_size(int'(hdata[IMG_H_W-1:0]), MAX_HEIGHT);
    endtask

    task automatic run_frame(input bit noisy, input bit cut_short, input bit pause);
        int npx;
        int stop;
        npx  = cur_w * cur_h;
        stop = cut_short ? $urandom_range(1, npx) : npx;
        for (int i = 0; i < stop; i++)
        begin
            // stray drain while pixels are still due, must be ignored
            if (noisy && $urandom_range(0, 19) == 0)
                send_item(ACT_DRAIN, TDATA_W'($urandom));
            if (pause && i == npx / 2)
                wait_results();
            send_item(ACT_PIXEL, TDATA_W'($urandom));
            if (noisy)
                random_items++;
        end
        if (cut_short)
        begin
            restarts++;
            return;
        end
        for (int d = 0; d <= cur_w; d++)
        begin
            send_item((noisy && $urandom_range(0, 3) == 0) ? ACT_PIXEL : ACT_DRAIN,
                      TDATA_W'($urandom));
            if (noisy)
                random_items++;
        end
        if (noisy && $urandom_range(0, 9) == 0)
            send_item(ACT_DRAIN, TDATA_W'($urandom));
        frames++;
    endtask

    initial
    begin : stimulus
        bit cut_short;
        int round;
        int wv;
        int hv;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes: 640 wide, so a handful of pixels gives no output yet
        for (int i = 0; i < 8; i++)
            send_item(ACT_PIXEL, TDATA_W'($urandom));
        wait_results();
        restarts++;

        // one pixel frame: a leading drain is ignored, a pixel while flushing drains
        write_size(1, 1);
        send_item(ACT_DRAIN, 24'hFFFFFF);
        send_item(ACT_PIXEL, 24'hFFFFFF);
        send_item(ACT_DRAIN, 24'h000000);
        send_item(ACT_PIXEL, 24'h000000);
        wait_results();

        // full-scale checkerboard with a stray drain in the middle
        write_size(3, 3);
        for (int i = 0; i < 9; i++)
        begin
            send_item(ACT_PIXEL, i[0] ? 24'hFFFFFF : 24'h000000);
            if (i == 4)
                send_item(ACT_DRAIN, 24'h00FF00);
        end
        for (int d = 0; d <= 3; d++)
            send_item((d == 2) ? ACT_PIXEL : ACT_DRAIN, 24'hFF00FF);
        wait_results();

        // zero sizes act as 1; the width write carries junk above its 11 bits
        write_size(13'h1800, 13'h0000);
        send_item(ACT_PIXEL, 24'h80FF01);
        send_item(ACT_DRAIN, 24'h000000);
        send_item(ACT_DRAIN, 24'h000000);
        wait_results();

        // frame abandoned partway, the next write restarts it
        write_size(4, 3);
        for (int i = 0; i < 5; i++)
            send_item(ACT_PIXEL, TDATA_W'($urandom));
        wait_results();
        restarts++;

        cut_short = 1'b1;
        round     = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            tx_fast = ($urandom_range(0, 3) == 0);
            rx_fast = ($urandom_range(0, 3) == 0);
            if (round == 0)
            begin
                // sender runs flat out into a held output so the core backs up
                wait_results();
                write_size(13'd12, 13'd6);
                tx_fast = 1'b1;
                rx_hold = 1'b1;
            end
            else if (cut_short || $urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 15))
                    0:       wv = 0;
                    1:       wv = $urandom_range(13, 40);
                    default: wv = $urandom_range(1, 12);
                endcase
                case ($urandom_range(0, 15))
                    0:       hv = 0;
                    1:       hv = $urandom_range(7, 12);
                    default: hv = $urandom_range(1, 6);
                endcase
                wait_results();
                write_size({2'($urandom_range(0, 3)), 11'(wv)}, 13'(hv));
            end
            cut_short = (round > 1) && ($urandom_range(0, 9) == 0);
            run_frame(1'b1, cut_short,
                      round == 1 || (round != 0 && $urandom_range(0, 5) == 0));
            round++;
        end
        wait_results();

        $display("%0d input transactions, %0d complete frames, %0d cut short, %0d results checked",
                 accepted, frames, restarts, checked);
        $display("sizes 1x1 up to 40x12, zero sizes, idle gaps, bursts, long output hold");
        if (fail_count == 0)
            $display("** box_blur_3x3_rgb_core: PASSED **");
        else
            $display("** box_blur_3x3_rgb_core: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
rtl/bb3_pkg.sv
rtl/bb3_ram.sv
rtl/bb3_ctrl.sv
rtl/bb3_window.sv
rtl/bb3_norm.sv
rtl/box_blur_3x3_rgb_core.sv
rtl/bb3_checker.sv
bench/box_blur_3x3_rgb_checker.sv
bench/box_blur_3x3_rgb_core_tb.sv
